// ===== sv/ipv4al_pkg.sv =====
`default_nettype none
package ipv4al_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Item field widths
	localparam int OPCODE_W = 2;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W  = 13;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

	// All-ones address marks an invalid entry
	localparam logic [ADDR_W-1:0] ADDR_INVALID = '1;

	// Table memory access from the sequencer
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [ADDR_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	// One finished result
	typedef struct packed {
		logic                allowed;
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  entry_count;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/ipv4al_req_if.sv =====
`default_nettype none
interface ipv4al_req_if import ipv4al_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ADDR_W-1:0]   address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink (input valid, input opcode, input address, output ready);
endinterface
`default_nettype wire

// ===== sv/ipv4al_rsp_if.sv =====
`default_nettype none
interface ipv4al_rsp_if import ipv4al_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                allowed;
	logic [STATUS_W-1:0] status;
	logic [ENTRY_W-1:0]  entry_count;

	modport source (output valid, output allowed, output status, output entry_count,
		input ready);
	modport sink (input valid, input allowed, input status, input entry_count,
		output ready);
endinterface
`default_nettype wire

// ===== sv/ipv4al_mem.sv =====
`default_nettype none
module ipv4al_mem import ipv4al_pkg::*; (
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [ADDR_W-1:0] rdata
);

	logic [ADDR_W-1:0] mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/ipv4al_seq.sv =====
`default_nettype none
module ipv4al_seq import ipv4al_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPCODE_W-1:0] in_opcode,
	input  wire logic [ADDR_W-1:0]   in_address,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output result_t                  res,
	output mem_req_t                 mem_req,
	input  wire logic [ADDR_W-1:0]   mem_rdata
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN_RD  = 3'd1;
	localparam logic [2:0] S_SCAN_CMP = 3'd2;
	localparam logic [2:0] S_SH_RD    = 3'd3;
	localparam logic [2:0] S_SH_WR    = 3'd4;
	localparam logic [2:0] S_APPEND   = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [OPCODE_W-1:0] op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [IDX_W-1:0]    idx_q;
	logic                allowed_q;
	logic [STATUS_W-1:0] status_q;

	logic [CNT_W-1:0] idx_next;
	logic             hit;
	logic             last;

	// Shared compare unit: one stored entry against the item address per pass
	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
	assign hit      = (mem_rdata == addr_q);
	assign last     = (idx_next >= count_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);

	assign res.allowed     = allowed_q;
	assign res.status      = status_q;
	assign res.entry_count = ENTRY_W'(count_q);

	// Memory port select
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = mem_rdata;
		mem_req.raddr = idx_q;
		case (state_q)
			S_SH_RD: begin
				mem_req.raddr = idx_q + IDX_W'(1);
			end
			S_SH_WR: begin
				mem_req.we = 1'b1;
			end
			S_APPEND: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(count_q);
				mem_req.wdata = addr_q;
			end
			default: begin
			end
		endcase
	end

	// Item payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q   <= in_opcode;
					addr_q <= in_address;
					idx_q  <= '0;
				end
			end
			S_SCAN_CMP: begin
				if (!hit && !last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_SH_WR: begin
				idx_q <= idx_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			allowed_q <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						allowed_q <= 1'b0;
						status_q  <= ST_OK;
						case (in_opcode)
							OP_LOOKUP: begin
								if (count_q == '0) begin
									allowed_q <= 1'b1;
									state_q   <= S_FIN;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							OP_ADD: begin
								if (count_q >= CNT_W'(TABLE_DEPTH)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else if (in_address == ADDR_INVALID) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (count_q == '0) begin
									state_q <= S_APPEND;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							OP_REMOVE: begin
								if (in_address == ADDR_INVALID) begin
									status_q <= ST_INVALID;
									state_q  <= S_FIN;
								end else if (count_q == '0) begin
									status_q <= ST_NOT_FOUND;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (hit) begin
						case (op_q)
							OP_LOOKUP: begin
								allowed_q <= 1'b1;
								state_q   <= S_FIN;
							end
							OP_ADD: begin
								status_q <= ST_PRESENT;
								state_q  <= S_FIN;
							end
							OP_REMOVE: begin
								state_q <= S_SH_RD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end else if (last) begin
						case (op_q)
							OP_ADD: begin
								state_q <= S_APPEND;
							end
							OP_REMOVE: begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				// Compaction: pull the next entry down one place
				S_SH_RD: begin
					if (idx_next < count_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_SH_WR: begin
					state_q <= S_SH_RD;
				end
				S_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/ipv4_allowlist_table_core.sv =====
// Operation: an item is accepted in the idle state, then a lookup or add scans each stored
//   entry with a read state and a compare state; a remove scans to the match and then
//   compacts each later entry with a read state and a write state.
// Throughput: one item at a time, set by the single table read port and compare unit.
// Reset clears the entry count, sequencer and output valid flag; table contents are left
//   as they are and only entries below the count are ever used.
`default_nettype none
module ipv4_allowlist_table_core import ipv4al_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ipv4al_req_if.sink   req,
	ipv4al_rsp_if.source rsp
);

	mem_req_t          mem_req;
	logic [ADDR_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;

	logic                out_valid_q;
	logic                out_allowed_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ENTRY_W-1:0]  out_count_q;

	ipv4al_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	ipv4al_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_opcode  (req.opcode),
		.in_address (req.address),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	// Output register: takes a result when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_allowed_q <= res.allowed;
			out_status_q  <= res.status;
			out_count_q   <= res.entry_count;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.allowed     = out_allowed_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

`ifndef ASSERT_OFF
	// The sequencer is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accepted a second item back to back");

	// Only a lookup answer can allow, and lookups report ok
	a_allowed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.allowed |-> rsp.status == ST_OK)
		else $error("allowed with non-ok status");

	// Reported count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= ENTRY_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// No table write while waiting for an item
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !mem_req.we)
		else $error("table write while idle");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
	import ipv4al_pkg::*;

	// Opcode 3 is unused by the block: no change, allowed 0, status ok
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	localparam int IDLE_PCT       = 18;
	localparam int RANDOM_ITEMS   = 75;
	localparam int POOL_SIZE      = 12;
	localparam int QUIET_LO       = 60;
	localparam int QUIET_HI       = 90;
	localparam int HOLD_AFTER     = 30;
	localparam int HOLD_CYCLES    = 300;
	// Filling the table scans every stored entry for each add; only shallow tables are filled
	localparam int FILL_DEPTH_MAX = 512;
	localparam int ITEM_CYCLES    = 2 * TABLE_DEPTH + 3;
	localparam int WATCHDOG_LIMIT = 4 * ITEM_CYCLES + 4 * HOLD_CYCLES;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [ADDR_W-1:0]   addr;
		logic                typed;
		result_t             want;
	} table_op_t;

	logic clk;
	logic arst_n;

	ipv4al_req_if req_ch ();
	ipv4al_rsp_if rsp_ch ();

	ipv4_allowlist_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted table contents, packed in insertion order
	logic [ADDR_W-1:0] allow_list[$];
	result_t           pending_results[$];
	table_op_t         op_plan[$];
	int                mismatch_count = 0;
	int                results_seen = 0;
	bit                hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void plan_item(input logic [OPCODE_W-1:0] op,
		input logic [ADDR_W-1:0] addr, input logic typed = 1'b0,
		input logic allowed = 1'b0, input logic [STATUS_W-1:0] status = ST_OK,
		input int count = 0);
		table_op_t row;
		row.op                = op;
		row.addr              = addr;
		row.typed             = typed;
		row.want.allowed      = allowed;
		row.want.status       = status;
		row.want.entry_count  = ENTRY_W'(count);
		op_plan.push_back(row);
	endfunction

	// Apply one operation to the predicted table and return its result
	function automatic result_t apply_table_op(input logic [OPCODE_W-1:0] op,
		input logic [ADDR_W-1:0] addr);
		result_t r;
		int      hit;
		r   = '0;
		hit = -1;
		foreach (allow_list[k])
			if (hit < 0 && allow_list[k] == addr) hit = k;
		case (op)
			OP_LOOKUP: begin
				r.allowed = (allow_list.size() == 0) || (hit >= 0);
			end
			OP_ADD: begin
				if (allow_list.size() >= TABLE_DEPTH) r.status = ST_FULL;
				else if (addr == ADDR_INVALID) r.status = ST_INVALID;
				else if (hit >= 0) r.status = ST_PRESENT;
				else allow_list.push_back(addr);
			end
			OP_REMOVE: begin
				if (addr == ADDR_INVALID) r.status = ST_INVALID;
				else if (hit < 0) r.status = ST_NOT_FOUND;
				else allow_list.delete(hit);
			end
			default: begin
			end
		endcase
		r.entry_count = ENTRY_W'(allow_list.size());
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	// Compare one accepted result against the oldest prediction
	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result allowed=%0b status=%0d count=%0d",
				rsp_ch.allowed, rsp_ch.status, rsp_ch.entry_count));
		end else begin
			want = pending_results.pop_front();
			if (rsp_ch.allowed !== want.allowed)
				flag_mismatch($sformatf("allowed %0b, expected %0b",
					rsp_ch.allowed, want.allowed));
			if (rsp_ch.status !== want.status)
				flag_mismatch($sformatf("status %0d, expected %0d",
					rsp_ch.status, want.status));
			if (rsp_ch.entry_count !== want.entry_count)
				flag_mismatch($sformatf("entry_count %0d, expected %0d",
					rsp_ch.entry_count, want.entry_count));
		end
		results_seen++;
	endtask

	// Reset, stimulus and end of run
	initial begin
		logic [ADDR_W-1:0]   addr_pool[POOL_SIZE];
		logic [OPCODE_W-1:0] op;
		logic [ADDR_W-1:0]   addr;
		int                  pick;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_LOOKUP;
		req_ch.address <= '0;

		// Directed: empty table, rejects, extremes, compaction
		plan_item(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, ST_OK, 0);
		plan_item(OP_LOOKUP, ADDR_INVALID, 1'b1, 1'b1, ST_OK, 0);
		plan_item(OP_REMOVE, 32'h0A00_0001, 1'b1, 1'b0, ST_NOT_FOUND, 0);
		plan_item(OP_REMOVE, ADDR_INVALID, 1'b1, 1'b0, ST_INVALID, 0);
		plan_item(OP_ADD, ADDR_INVALID, 1'b1, 1'b0, ST_INVALID, 0);
		plan_item(OP_ADD, 32'h0000_0000, 1'b1, 1'b0, ST_OK, 1);
		plan_item(OP_ADD, 32'hFFFF_FFFE, 1'b1, 1'b0, ST_OK, 2);
		plan_item(OP_ADD, 32'h0000_0000, 1'b1, 1'b0, ST_PRESENT, 2);
		plan_item(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, ST_OK, 2);
		plan_item(OP_LOOKUP, ADDR_INVALID, 1'b1, 1'b0, ST_OK, 2);
		plan_item(OP_LOOKUP, 32'hFFFF_FFFE, 1'b1, 1'b1, ST_OK, 2);
		plan_item(OP_ADD, 32'hC0A8_0001, 1'b1, 1'b0, ST_OK, 3);
		plan_item(OP_ADD, 32'h8000_0000, 1'b1, 1'b0, ST_OK, 4);
		plan_item(OP_ADD, 32'h7FFF_FFFF, 1'b1, 1'b0, ST_OK, 5);
		plan_item(OP_UNUSED, 32'hC0A8_0001, 1'b1, 1'b0, ST_OK, 5);
		plan_item(OP_REMOVE, 32'hFFFF_FFFE, 1'b1, 1'b0, ST_OK, 4);
		plan_item(OP_LOOKUP, 32'h8000_0000);
		plan_item(OP_LOOKUP, 32'hFFFF_FFFE, 1'b1, 1'b0, ST_OK, 4);
		plan_item(OP_REMOVE, 32'h7FFF_FFFF, 1'b1, 1'b0, ST_OK, 3);
		plan_item(OP_REMOVE, 32'h0000_0000, 1'b1, 1'b0, ST_OK, 2);
		plan_item(OP_LOOKUP, 32'hC0A8_0001);
		plan_item(OP_REMOVE, 32'hC0A8_0001, 1'b1, 1'b0, ST_OK, 1);
		plan_item(OP_REMOVE, 32'h8000_0000, 1'b1, 1'b0, ST_OK, 0);
		plan_item(OP_LOOKUP, 32'h1234_5678, 1'b1, 1'b1, ST_OK, 0);
		plan_item(OP_REMOVE, 32'h8000_0000, 1'b1, 1'b0, ST_NOT_FOUND, 0);

		// Full table: full is reported ahead of invalid and present
		if (TABLE_DEPTH <= FILL_DEPTH_MAX) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				plan_item(OP_ADD, ADDR_W'(32'h0A00_0000 + i));
			plan_item(OP_ADD, 32'h0B00_0000);
			plan_item(OP_ADD, ADDR_INVALID);
			plan_item(OP_ADD, 32'h0A00_0000);
			plan_item(OP_LOOKUP, ADDR_W'(32'h0A00_0000 + TABLE_DEPTH - 1));
			plan_item(OP_LOOKUP, 32'h0B00_0000);
			for (int i = 0; i < TABLE_DEPTH; i++)
				plan_item(OP_REMOVE, ADDR_W'(32'h0A00_0000 + i));
		end

		// Random: mostly a small pool so adds, removes and lookups hit
		foreach (addr_pool[k]) addr_pool[k] = $urandom();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) op = OP_LOOKUP;
			else if (pick < 70) op = OP_ADD;
			else if (pick < 95) op = OP_REMOVE;
			else op = OP_UNUSED;
			pick = $urandom_range(99);
			if (pick < 60) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
			else if (pick < 92) addr = $urandom();
			else addr = ADDR_INVALID;
			plan_item(op, addr);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Offer items; predict each one at its handshake
		for (int i = 0; i < op_plan.size(); i++) begin
			if (!(i >= QUIET_LO && i < QUIET_HI)) begin
				while ($urandom_range(99) < IDLE_PCT) begin
					req_ch.valid <= 1'b0;
					@(posedge clk);
				end
			end
			req_ch.valid   <= 1'b1;
			req_ch.opcode  <= op_plan[i].op;
			req_ch.address <= op_plan[i].addr;
			@(posedge clk);
			while (!req_ch.ready) @(posedge clk);
			begin
				result_t predicted;
				predicted = apply_table_op(op_plan[i].op, op_plan[i].addr);
				pending_results.push_back(op_plan[i].typed ? op_plan[i].want : predicted);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (ITEM_CYCLES + 16) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: random stalls, one long hold, a stretch with no stalls
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) check_result();
		end
	end

	// Watchdog: too many cycles with no item moving on either side
	initial begin
		int quiet_run;
		quiet_run = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		while (quiet_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_run = 0;
			else
				quiet_run++;
		end
		$display("TIMEOUT after %0d quiet cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/ipv4al_pkg.sv
sv/ipv4al_req_if.sv
sv/ipv4al_rsp_if.sv
sv/ipv4al_mem.sv
sv/ipv4al_seq.sv
sv/ipv4_allowlist_table_core.sv
tb/tb_top.sv
